[src/npe_pkg.sv]
// Shared types and constants of the next-permutation engine.
package npe_pkg;

   localparam int MAX_LENGTH_DEF = 16;
   localparam int BYTE_W         = 8;
   localparam int CMD_W          = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_STEP   = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_FIND_RD,
      ST_FIND_CMP,
      ST_SWAP2,
      ST_REV_RD,
      ST_REV_W1,
      ST_REV_W2,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   typedef enum logic [1:0] {
      WSEL_VALUE,
      WSEL_Q0,
      WSEL_Q1,
      WSEL_PIVOT
   } wsel_type;

   typedef struct packed {
      logic     rd_en;
      logic     wr_en;
      wsel_type wr_sel;
      logic     latch_pivot;
      logic     load_out;
      logic     out_last;
      logic     out_adv;
   } dp_ctrl_type;

   typedef struct packed {
      logic q0_lt_q1;
      logic pivot_lt_q0;
      logic out_free;
   } dp_status_type;

endpackage

[src/npe_req_if.sv]
// Request and response channel interfaces of the next-permutation engine.
interface npe_req_if;
   import npe_pkg::*;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [BYTE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface npe_rsp_if;
   import npe_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] element;
   logic              last_of_run;
   logic              advanced;

   modport source (output valid, output element, output last_of_run, output advanced,
                   input ready);
   modport sink   (input valid, input element, input last_of_run, input advanced,
                   output ready);
endinterface

[src/npe_datapath.sv]
// Datapath: element memory, read registers, pivot and result word register.
module npe_datapath #(
   parameter int MAX_LENGTH = npe_pkg::MAX_LENGTH_DEF,
   parameter int AW         = $clog2(MAX_LENGTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  npe_pkg::dp_ctrl_type       ctrl,
   output npe_pkg::dp_status_type     status,
   input  logic [AW-1:0]              rd_addr0,
   input  logic [AW-1:0]              rd_addr1,
   input  logic [AW-1:0]              wr_addr,
   input  logic [npe_pkg::BYTE_W-1:0] req_value,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [npe_pkg::BYTE_W-1:0] rsp_element,
   output logic                       rsp_last_of_run,
   output logic                       rsp_advanced
);
   import npe_pkg::*;

   logic [BYTE_W-1:0] mem [MAX_LENGTH];
   logic [BYTE_W-1:0] q0_ff, q1_ff;
   logic [BYTE_W-1:0] pivot_ff;
   logic [BYTE_W-1:0] wr_data;
   logic [BYTE_W-1:0] elem_ff;
   logic              last_ff, adv_ff;
   logic              valid_ff, valid_in;

   always_comb begin
      unique case (ctrl.wr_sel)
         WSEL_VALUE: wr_data = req_value;
         WSEL_Q0:    wr_data = q0_ff;
         WSEL_Q1:    wr_data = q1_ff;
         WSEL_PIVOT: wr_data = pivot_ff;
         default:    wr_data = req_value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         q0_ff <= mem[rd_addr0];
         q1_ff <= mem[rd_addr1];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.latch_pivot) begin
         pivot_ff <= q0_ff;
      end
      if (ctrl.load_out) begin
         elem_ff <= q0_ff;
         last_ff <= ctrl.out_last;
         adv_ff  <= ctrl.out_adv;
      end
   end

   // The result register frees up in the same cycle that its word is taken.
   assign status.out_free    = !valid_ff || rsp_ready;
   assign status.q0_lt_q1    = q0_ff < q1_ff;
   assign status.pivot_lt_q0 = pivot_ff < q0_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.load_out) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_element     = elem_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_advanced    = adv_ff;
endmodule

[src/npe_controller.sv]
// Controller: command decode, length count and the step sequencer.
module npe_controller #(
   parameter int MAX_LENGTH = npe_pkg::MAX_LENGTH_DEF,
   parameter int AW         = $clog2(MAX_LENGTH),
   parameter int LW         = $clog2(MAX_LENGTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [npe_pkg::CMD_W-1:0] req_cmd,
   output logic                      req_ready,
   output npe_pkg::dp_ctrl_type      ctrl,
   input  npe_pkg::dp_status_type    status,
   output logic [AW-1:0]             rd_addr0,
   output logic [AW-1:0]             rd_addr1,
   output logic [AW-1:0]             wr_addr
);
   import npe_pkg::*;

   state_type     state_ff, state_in;
   logic [LW-1:0] len_ff, len_in;
   logic [AW-1:0] k_ff, k_in;
   logic [AW-1:0] p_ff, p_in;
   logic [AW-1:0] lo_ff, lo_in;
   logic [AW-1:0] hi_ff, hi_in;
   logic          adv_ff, adv_in;
   logic [AW-1:0] last_idx;
   logic          accept;

   assign last_idx  = AW'(len_ff - LW'(1));
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff   <= '0;
         adv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         adv_ff   <= adv_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff  <= k_in;
      p_ff  <= p_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
   end

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      k_in     = k_ff;
      p_in     = p_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      adv_in   = adv_ff;
      ctrl     = '{rd_en: 1'b0, wr_en: 1'b0, wr_sel: WSEL_VALUE, latch_pivot: 1'b0,
                   load_out: 1'b0, out_last: 1'b0, out_adv: adv_ff};
      rd_addr0 = lo_ff;
      rd_addr1 = hi_ff;
      wr_addr  = AW'(len_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     len_in = '0;
                  end
                  CMD_APPEND: begin
                     if (len_ff < LW'(MAX_LENGTH)) begin
                        ctrl.wr_en = 1'b1;
                        len_in     = len_ff + LW'(1);
                     end
                  end
                  CMD_STEP: begin
                     adv_in = 1'b0;
                     lo_in  = '0;
                     k_in   = last_idx;
                     if (len_ff == LW'(1)) begin
                        state_in = ST_EMIT_RD;
                     end else if (len_ff != '0) begin
                        state_in = ST_SCAN_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            ctrl.rd_en = 1'b1;
            rd_addr0   = k_ff - AW'(1);
            rd_addr1   = k_ff;
            state_in   = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            if (status.q0_lt_q1) begin
               ctrl.latch_pivot = 1'b1;
               p_in             = last_idx;
               state_in         = ST_FIND_RD;
            end else if (k_ff == AW'(1)) begin
               // No ascent anywhere: the whole run is non-increasing, so reverse it all.
               lo_in    = '0;
               hi_in    = last_idx;
               state_in = ST_REV_RD;
            end else begin
               k_in     = k_ff - AW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_FIND_RD: begin
            ctrl.rd_en = 1'b1;
            rd_addr0   = p_ff;
            state_in   = ST_FIND_CMP;
         end
         ST_FIND_CMP: begin
            if (status.pivot_lt_q0) begin
               ctrl.wr_en  = 1'b1;
               ctrl.wr_sel = WSEL_Q0;
               wr_addr     = k_ff - AW'(1);
               state_in    = ST_SWAP2;
            end else begin
               p_in     = p_ff - AW'(1);
               state_in = ST_FIND_RD;
            end
         end
         ST_SWAP2: begin
            ctrl.wr_en  = 1'b1;
            ctrl.wr_sel = WSEL_PIVOT;
            wr_addr     = p_ff;
            adv_in      = 1'b1;
            lo_in       = k_ff;
            hi_in       = last_idx;
            state_in    = ST_REV_RD;
         end
         ST_REV_RD: begin
            if (lo_ff < hi_ff) begin
               ctrl.rd_en = 1'b1;
               state_in   = ST_REV_W1;
            end else begin
               lo_in    = '0;
               state_in = ST_EMIT_RD;
            end
         end
         ST_REV_W1: begin
            ctrl.wr_en  = 1'b1;
            ctrl.wr_sel = WSEL_Q1;
            wr_addr     = lo_ff;
            state_in    = ST_REV_W2;
         end
         ST_REV_W2: begin
            ctrl.wr_en  = 1'b1;
            ctrl.wr_sel = WSEL_Q0;
            wr_addr     = hi_ff;
            lo_in       = lo_ff + AW'(1);
            hi_in       = hi_ff - AW'(1);
            state_in    = ST_REV_RD;
         end
         ST_EMIT_RD: begin
            ctrl.rd_en = 1'b1;
            rd_addr0   = lo_ff;
            state_in   = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (status.out_free) begin
               ctrl.load_out = 1'b1;
               ctrl.out_last = (lo_ff == last_idx);
               if (lo_ff == last_idx) begin
                  state_in = ST_IDLE;
               end else begin
                  lo_in    = lo_ff + AW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

[src/next_permutation_engine_unit.sv]
// Clear and append are done as they are accepted; a step on L >= 2 stored bytes holds the
// input through scan, partner search, swap, tail reversal and emission, output stalls included,
// paced by the single write port and the registered reads of the element memory. Results
// leave through a one-word output register: each byte is read into a read register, then
// loaded into the output register, and the next byte is read only after that load.
// Synchronous active-high reset empties the sequence, idles the sequencer and drops the output.
module next_permutation_engine_unit #(
   parameter int MAX_LENGTH = npe_pkg::MAX_LENGTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   npe_req_if.sink   req_bus,
   npe_rsp_if.source rsp_bus
);
   import npe_pkg::*;

   localparam int AW = $clog2(MAX_LENGTH);
   localparam int LW = $clog2(MAX_LENGTH + 1);

   dp_ctrl_type   ctrl;
   dp_status_type status;
   logic [AW-1:0] rd_addr0, rd_addr1, wr_addr;
   logic          req_ready;

   assign req_bus.ready = req_ready;

   npe_controller #(
      .MAX_LENGTH (MAX_LENGTH),
      .AW         (AW),
      .LW         (LW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_cmd   (req_bus.cmd),
      .req_ready (req_ready),
      .ctrl      (ctrl),
      .status    (status),
      .rd_addr0  (rd_addr0),
      .rd_addr1  (rd_addr1),
      .wr_addr   (wr_addr)
   );

   npe_datapath #(
      .MAX_LENGTH (MAX_LENGTH),
      .AW         (AW)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .rd_addr0        (rd_addr0),
      .rd_addr1        (rd_addr1),
      .wr_addr         (wr_addr),
      .req_value       (req_bus.value),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_element     (rsp_bus.element),
      .rsp_last_of_run (rsp_bus.last_of_run),
      .rsp_advanced    (rsp_bus.advanced)
   );
endmodule

[tb/npe_step_checker.sv]
// Checker that predicts the permutation words of each step and compares them with the outputs.
module npe_step_checker #(
   parameter int MAX_LEN = npe_pkg::MAX_LENGTH_DEF
) (
   input  logic clock,
   input  logic reset,
   npe_req_if   req_mon,
   npe_rsp_if   rsp_mon,
   output int   mismatches,
   output int   words_pending
);
   import npe_pkg::*;

   typedef struct packed {
      logic [BYTE_W-1:0] element;
      logic              last_of_run;
      logic              advanced;
   } perm_word_type;

   perm_word_type     expected_words[$];
   logic [BYTE_W-1:0] seq_bytes[MAX_LEN];
   int                seq_len;

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
   endtask

   function void swap_bytes(input int a, input int b);
      logic [BYTE_W-1:0] t;
      t = seq_bytes[a];
      seq_bytes[a] = seq_bytes[b];
      seq_bytes[b] = t;
   endfunction

   function void reverse_span(input int lo, input int hi_excl);
      while (hi_excl > lo + 1) begin
         hi_excl--;
         swap_bytes(lo, hi_excl);
         lo++;
      end
   endfunction

   // Rewrites the stored bytes into the next larger arrangement; returns 0 when
   // the sequence was already the largest (it wraps to ascending) or too short.
   function logic next_lex_order();
      int k;
      int p;
      if (seq_len < 2) return 1'b0;
      k = seq_len - 1;
      while (k > 0 && !(seq_bytes[k-1] < seq_bytes[k])) k--;
      if (k == 0) begin
         reverse_span(0, seq_len);
         return 1'b0;
      end
      p = seq_len - 1;
      while (!(seq_bytes[k-1] < seq_bytes[p])) p--;
      swap_bytes(k - 1, p);
      reverse_span(k, seq_len);
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      perm_word_type got;
      perm_word_type want;
      logic          adv;
      if (reset) begin
         seq_len = 0;
         expected_words.delete();
      end else begin
         // Outgoing words belong to older steps, so they are matched before
         // a step accepted at this same edge queues its own words.
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got = '{rsp_mon.element, rsp_mon.last_of_run, rsp_mon.advanced};
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("word with no step pending, element %0d",
                                         got.element));
            end else begin
               want = expected_words.pop_front();
               if (got.element !== want.element)
                  report_mismatch($sformatf("element got %0d expected %0d",
                                            got.element, want.element));
               if (got.last_of_run !== want.last_of_run)
                  report_mismatch($sformatf("last_of_run got %b expected %b",
                                            got.last_of_run, want.last_of_run));
               if (got.advanced !== want.advanced)
                  report_mismatch($sformatf("advanced got %b expected %b",
                                            got.advanced, want.advanced));
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            case (req_mon.cmd)
               CMD_CLEAR: begin
                  seq_len = 0;
               end
               CMD_APPEND: begin
                  if (seq_len < MAX_LEN) begin
                     seq_bytes[seq_len] = req_mon.value;
                     seq_len++;
                  end
               end
               CMD_STEP: begin
                  if (seq_len > 0) begin
                     adv = next_lex_order();
                     for (int i = 0; i < seq_len; i++)
                        expected_words.push_back('{seq_bytes[i], i == seq_len - 1, adv});
                  end
               end
               default: ;
            endcase
         end
      end
      words_pending = expected_words.size();
   end

endmodule

[tb/next_permutation_engine_unit_tb.sv]
// Top of the next-permutation engine testbench: clock, reset, stimulus and verdict.
module next_permutation_engine_unit_tb;
   import npe_pkg::*;

   localparam int          MAX_LEN      = MAX_LENGTH_DEF;
   localparam logic [1:0]  CMD_RESERVED = 2'd3;
   localparam int          ITEM_TARGET  = 220;

   logic clock;
   logic reset;
   int   mismatches;
   int   words_pending;
   int   rsp_words;
   int   items_counted;
   int   fill;
   int   req_gap_pct;

   npe_req_if req_bus();
   npe_rsp_if rsp_bus();

   next_permutation_engine_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   npe_step_checker #(.MAX_LEN(MAX_LEN)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .mismatches    (mismatches),
      .words_pending (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 600000);
      $display("FAIL next_permutation_engine_unit");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) rsp_words <= rsp_words + 1;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_pct();
      case ($urandom_range(0, 2))
         0:       return 0;
         1:       return 15;
         default: return 50;
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken.
   task automatic send_word(input logic [1:0] cmd, input logic [7:0] value);
      int idle;
      idle = ($urandom_range(0, 99) < req_gap_pct) ? idle_len() : 0;
      if (idle > 0) begin
         req_bus.valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd   <= cmd;
      req_bus.value <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
      // Reserved commands and appends to a full sequence change nothing.
      if (cmd == CMD_CLEAR) begin
         fill = 0;
         items_counted++;
      end else if (cmd == CMD_APPEND) begin
         if (fill < MAX_LEN) begin
            fill++;
            items_counted++;
         end
      end else if (cmd == CMD_STEP) begin
         items_counted++;
      end
   endtask

   // Output side: random stall windows, plus one long hold that backs the block up.
   initial begin
      int   stall_left;
      int   window_left;
      int   stall_pct;
      logic long_hold_done;
      rsp_bus.ready  = 1'b0;
      stall_left     = 0;
      window_left    = 0;
      stall_pct      = 0;
      long_hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (window_left == 0) begin
            window_left = 64;
            stall_pct   = pick_pct();
         end
         window_left--;
         if (!long_hold_done && rsp_words >= 60) begin
            long_hold_done = 1'b1;
            stall_left     = 400;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < stall_pct) begin
            rsp_bus.ready <= 1'b0;
            stall_left = idle_len() - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int         seq_n;
      int         extra;
      int         steps;
      int         lo_val;
      int         span;
      logic       small_alphabet;
      logic       first_seq;
      logic       paused;
      logic [1:0] noise_cmd;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd   = CMD_CLEAR;
      req_bus.value = '0;
      rsp_words     = 0;
      items_counted = 0;
      fill          = 0;
      req_gap_pct   = 0;
      first_seq     = 1'b1;
      paused        = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty step, single byte, byte extremes, wrap, repeated bytes.
      send_word(CMD_STEP, 8'hA5);
      send_word(CMD_APPEND, 8'd7);
      send_word(CMD_STEP, 8'h00);
      send_word(CMD_CLEAR, 8'hFF);
      send_word(CMD_APPEND, 8'd0);
      send_word(CMD_APPEND, 8'd255);
      send_word(CMD_STEP, 8'h00);
      send_word(CMD_STEP, 8'h00);
      send_word(CMD_CLEAR, 8'h00);
      send_word(CMD_APPEND, 8'd1);
      send_word(CMD_APPEND, 8'd2);
      send_word(CMD_APPEND, 8'd2);
      send_word(CMD_STEP, 8'h00);
      send_word(CMD_RESERVED, 8'h5A);
      send_word(CMD_STEP, 8'h00);
      send_word(CMD_STEP, 8'h00);
      send_word(CMD_CLEAR, 8'h00);
      send_word(CMD_APPEND, 8'd9);
      send_word(CMD_APPEND, 8'd9);
      send_word(CMD_APPEND, 8'd9);
      send_word(CMD_STEP, 8'h00);

      while (items_counted < ITEM_TARGET) begin
         req_gap_pct = pick_pct();
         if (first_seq || $urandom_range(0, 99) < 80) begin
            // Load a fresh sequence and walk through several permutations.
            case ($urandom_range(0, 9))
               0:       seq_n = $urandom_range(11, MAX_LEN);
               1, 2:    seq_n = $urandom_range(6, 10);
               default: seq_n = $urandom_range(2, 5);
            endcase
            extra = 0;
            if (first_seq || $urandom_range(0, 7) == 0) begin
               seq_n = MAX_LEN;
               extra = $urandom_range(1, 3);
            end
            first_seq      = 1'b0;
            small_alphabet = 1'($urandom_range(0, 1));
            lo_val         = $urandom_range(0, 253);
            span           = small_alphabet ? 2 : 255;
            send_word(CMD_CLEAR, 8'($urandom_range(0, 255)));
            for (int i = 0; i < seq_n + extra; i++) begin
               if (small_alphabet)
                  send_word(CMD_APPEND, 8'(lo_val + $urandom_range(0, span)));
               else
                  send_word(CMD_APPEND, 8'($urandom_range(0, 255)));
            end
            steps = (seq_n <= 3) ? $urandom_range(2, 8) : $urandom_range(1, 5);
            for (int s = 0; s < steps; s++) begin
               if ($urandom_range(0, 9) == 0)
                  send_word(CMD_APPEND, 8'($urandom_range(0, 255)));
               send_word(CMD_STEP, 8'($urandom_range(0, 255)));
            end
         end else begin
            for (int i = 0; i < $urandom_range(1, 4); i++) begin
               noise_cmd = 2'($urandom_range(0, 3));
               send_word(noise_cmd, 8'($urandom_range(0, 255)));
            end
         end
         // Once, halfway through, let the output drain completely before going on.
         if (!paused && items_counted > ITEM_TARGET / 2) begin
            paused = 1'b1;
            req_bus.valid <= 1'b0;
            wait (words_pending == 0);
            @(negedge clock);
         end
      end

      req_bus.valid <= 1'b0;
      wait (words_pending == 0);
      repeat (150) @(posedge clock);
      if (mismatches == 0 && words_pending == 0)
         $display("PASS next_permutation_engine_unit");
      else
         $display("FAIL next_permutation_engine_unit");
      $finish;
   end

endmodule
